// ===== rtl/core/bsc_pkg.sv =====
// Package for the bitboard symmetry canonicalizer: plane and key types,
// the bit masks of the mirror and transpose networks, and the compare function.
// Depends on nothing; every module of the block imports it.
package bsc_pkg;

    localparam int PlaneW    = 64;
    localparam int CodeW     = 3;
    localparam int NumImages = 8;

    typedef logic [PlaneW-1:0] t_plane;
    typedef logic [CodeW-1:0]  t_code;

    // Members are ordered by significance of the ordering key.
    typedef struct packed {
        t_plane top;
        t_plane mid;
        t_plane low;
        t_plane owner;
    } t_key;

    typedef struct packed {
        t_key  key;
        t_code code;
    } t_cand;

    // Bits of the symmetry code.
    localparam int CodeBitH = 0;
    localparam int CodeBitV = 1;
    localparam int CodeBitT = 2;

    localparam t_plane MaskNibHi = 64'hF0F0_F0F0_F0F0_F0F0;
    localparam t_plane MaskNibLo = 64'h0F0F_0F0F_0F0F_0F0F;
    localparam t_plane MaskPairHi = 64'hCCCC_CCCC_CCCC_CCCC;
    localparam t_plane MaskPairLo = 64'h3333_3333_3333_3333;
    localparam t_plane MaskBitHi = 64'hAAAA_AAAA_AAAA_AAAA;
    localparam t_plane MaskBitLo = 64'h5555_5555_5555_5555;
    localparam t_plane MaskT28 = 64'h0F0F_0F0F_0000_0000;
    localparam t_plane MaskT14 = 64'h3333_0000_3333_0000;
    localparam t_plane MaskT7  = 64'h5500_5500_5500_5500;

    // Reverse the bit order inside every byte.
    function automatic t_plane mirror_h(input t_plane b);
        t_plane r;
        r = ((b & MaskNibHi) >> 4) | ((b & MaskNibLo) << 4);
        r = ((r & MaskPairHi) >> 2) | ((r & MaskPairLo) << 2);
        r = ((r & MaskBitHi) >> 1) | ((r & MaskBitLo) << 1);
        return r;
    endfunction

    // Reverse the byte order, which flips the board top to bottom.
    function automatic t_plane swap_v(input t_plane b);
        t_plane r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = b[8*(7-i) +: 8];
        end
        return r;
    endfunction

    // Exchange square (row,col) with (col,row) by three delta swaps.
    function automatic t_plane transpose_t(input t_plane b);
        t_plane r;
        t_plane t;
        r = b;
        t = (r ^ (r << 28)) & MaskT28;
        r = r ^ t ^ (t >> 28);
        t = (r ^ (r << 14)) & MaskT14;
        r = r ^ t ^ (t >> 14);
        t = (r ^ (r << 7)) & MaskT7;
        r = r ^ t ^ (t >> 7);
        return r;
    endfunction

    function automatic t_plane map_plane(input t_plane b, input t_code code);
        t_plane r;
        r = b;
        if (code[CodeBitT]) r = transpose_t(r);
        if (code[CodeBitV]) r = swap_v(r);
        if (code[CodeBitH]) r = mirror_h(r);
        return r;
    endfunction

    // Lexicographic unsigned compare, one 64-bit compare per plane.
    function automatic logic key_less(input t_key a, input t_key b);
        logic lt_top, lt_mid, lt_low, lt_own;
        logic eq_top, eq_mid, eq_low;
        lt_top = a.top < b.top;
        lt_mid = a.mid < b.mid;
        lt_low = a.low < b.low;
        lt_own = a.owner < b.owner;
        eq_top = a.top == b.top;
        eq_mid = a.mid == b.mid;
        eq_low = a.low == b.low;
        return lt_top | (eq_top & (lt_mid | (eq_mid & (lt_low | (eq_low & lt_own)))));
    endfunction

endpackage

// ===== rtl/core/bsc_image.sv =====
// Input register stage of the canonicalizer and the eight symmetry images.
// Depends on bsc_pkg for the plane types and the transform functions.
module bsc_image (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  bsc_pkg::t_key        i_key,
    output logic                 o_valid,
    input  logic                 i_stall,
    output bsc_pkg::t_cand       o_cand [bsc_pkg::NumImages]
);
    import bsc_pkg::*;

    logic r_valid;
    t_key r_key;
    logic take;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_key <= i_key;
        end
    end

    assign o_valid = r_valid;

    // The images are pure wiring of the held position.
    for (genvar c = 0; c < NumImages; c++) begin : g_img
        assign o_cand[c].key.top   = map_plane(r_key.top, CodeW'(c));
        assign o_cand[c].key.mid   = map_plane(r_key.mid, CodeW'(c));
        assign o_cand[c].key.low   = map_plane(r_key.low, CodeW'(c));
        assign o_cand[c].key.owner = map_plane(r_key.owner, CodeW'(c));
        assign o_cand[c].code      = CodeW'(c);
    end

endmodule

// ===== rtl/core/bsc_reduce.sv =====
// One registered level of the minimum tree: pairs of candidates are compared
// and the lesser of each pair is kept. Depends on bsc_pkg.
module bsc_reduce #(
    parameter int NumIn = bsc_pkg::NumImages
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  bsc_pkg::t_cand       i_cand [NumIn],
    output logic                 o_valid,
    input  logic                 i_stall,
    output bsc_pkg::t_cand       o_cand [NumIn/2]
);
    import bsc_pkg::*;

    localparam int NumOut = NumIn / 2;

    logic  r_valid;
    t_cand r_cand [NumOut];
    t_cand n_cand [NumOut];
    logic  take;

    assign o_stall = r_valid && i_stall;
    assign take    = i_valid && !o_stall;

    // The right member wins only when strictly less, so ties keep the lower code.
    for (genvar j = 0; j < NumOut; j++) begin : g_pair
        always_comb begin
            if (key_less(i_cand[2*j+1].key, i_cand[2*j].key)) begin
                n_cand[j] = i_cand[2*j+1];
            end else begin
                n_cand[j] = i_cand[2*j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (take) begin
                r_cand[j] <= n_cand[j];
            end
        end

        assign o_cand[j] = r_cand[j];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    assign o_valid = r_valid;

endmodule

// ===== rtl/core/bitboard_symmetry_canonicalizer_top.sv =====
// Top level of the bitboard symmetry canonicalizer: input stage, three
// compare levels and the port wiring. Depends on bsc_pkg, bsc_image, bsc_reduce.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+-----------------------------------------
//  position | in        | i_valid / o_stall   | i_layer_low, i_layer_mid, i_layer_top,
//           |           |                     | i_owner_plane
//  result   | out       | o_valid / i_stall   | o_canon_low, o_canon_mid, o_canon_top,
//           |           |                     | o_canon_owner, o_sym_code
//
// A position is transferred in every cycle when the output side does not stall.
// Its result is offered at the output once the transfer has loaded the input register
// and the three registered levels of the eight-way minimum tree have passed it on,
// each level holding one 256-bit lexicographic compare per pair.
// The synchronous active-low reset clears only the valid bits of the stages.
// A stall holds each stage that is full and whose successor cannot move; empty
// stages keep filling, so up to four positions are in flight during a stall.
module bitboard_symmetry_canonicalizer_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [63:0]             i_layer_low,
    input  logic [63:0]             i_layer_mid,
    input  logic [63:0]             i_layer_top,
    input  logic [63:0]             i_owner_plane,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [63:0]             o_canon_low,
    output logic [63:0]             o_canon_mid,
    output logic [63:0]             o_canon_top,
    output logic [63:0]             o_canon_owner,
    output logic [2:0]              o_sym_code
);
    import bsc_pkg::*;

    t_key  in_key;
    t_cand img_cand [NumImages];
    t_cand l1_cand  [NumImages/2];
    t_cand l2_cand  [NumImages/4];
    t_cand l3_cand  [NumImages/8];
    logic  img_valid, l1_valid, l2_valid;
    logic  img_stall, l1_stall, l2_stall;

    // The key orders planes as top, mid, low, then owner.
    assign in_key.top   = i_layer_top;
    assign in_key.mid   = i_layer_mid;
    assign in_key.low   = i_layer_low;
    assign in_key.owner = i_owner_plane;

    bsc_image u_image (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_key   (in_key),
        .o_valid (img_valid),
        .i_stall (img_stall),
        .o_cand  (img_cand)
    );

    // Level one reduces eight images to four, comparing code pairs 0/1, 2/3 and so on.
    bsc_reduce #(.NumIn(NumImages)) u_lvl1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (img_valid),
        .o_stall (img_stall),
        .i_cand  (img_cand),
        .o_valid (l1_valid),
        .i_stall (l1_stall),
        .o_cand  (l1_cand)
    );

    bsc_reduce #(.NumIn(NumImages/2)) u_lvl2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (l1_valid),
        .o_stall (l1_stall),
        .i_cand  (l1_cand),
        .o_valid (l2_valid),
        .i_stall (l2_stall),
        .o_cand  (l2_cand)
    );

    // The last level is also the output register.
    bsc_reduce #(.NumIn(NumImages/4)) u_lvl3 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (l2_valid),
        .o_stall (l2_stall),
        .i_cand  (l2_cand),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cand  (l3_cand)
    );

    assign o_canon_low   = l3_cand[0].key.low;
    assign o_canon_mid   = l3_cand[0].key.mid;
    assign o_canon_top   = l3_cand[0].key.top;
    assign o_canon_owner = l3_cand[0].key.owner;
    assign o_sym_code    = l3_cand[0].code;

endmodule

// ===== sim/bitboard_symmetry_canonicalizer_top_tb.sv =====
// Self-checking testbench for bitboard_symmetry_canonicalizer_top: random and directed
// positions go in, and each canonical image and its symmetry code are checked in order.
// Depends on bsc_pkg for the plane, code and key types; nothing else is read.
`timescale 1ns / 100ps

module bitboard_symmetry_canonicalizer_top_tb;

    import bsc_pkg::*;

    // Number of random positions after the directed part.
    localparam int RandomCount    = 1950;
    // The last positions in the pending queue are sent with no idling on either side.
    localparam int QuietTail      = 200;
    // The long output hold-off starts once this many results have been checked.
    localparam int LongHoldAt     = 400;
    localparam int LongHoldCycles = 60;
    // Pipeline depth is four; wait a bit longer at the end for stray results.
    localparam int TailCycles     = 12;
    localparam int MaxReports     = 10;

    typedef struct {
        t_key key;
        bit   drain_first;   // hold this position back until every result is in
    } t_pos_item;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic        o_stall;
    logic [63:0] i_layer_low   = '0;
    logic [63:0] i_layer_mid   = '0;
    logic [63:0] i_layer_top   = '0;
    logic [63:0] i_owner_plane = '0;
    logic        o_valid;
    logic        i_stall       = 1'b0;
    logic [63:0] o_canon_low;
    logic [63:0] o_canon_mid;
    logic [63:0] o_canon_top;
    logic [63:0] o_canon_owner;
    logic [2:0]  o_sym_code;

    bitboard_symmetry_canonicalizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_layer_low   (i_layer_low),
        .i_layer_mid   (i_layer_mid),
        .i_layer_top   (i_layer_top),
        .i_owner_plane (i_owner_plane),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_canon_low   (o_canon_low),
        .o_canon_mid   (o_canon_mid),
        .o_canon_top   (o_canon_top),
        .o_canon_owner (o_canon_owner),
        .o_sym_code    (o_sym_code)
    );

    t_pos_item pending_q[$];   // positions still to be offered
    t_cand     canon_q[$];     // canonical images expected, oldest first

    bit rst_done  = 1'b0;
    bit in_taken  = 1'b0;      // the position on the inputs was transferred at the last edge
    bit quiet_r   = 1'b0;      // set by the driver once the tail of the run is reached
    bit long_done = 1'b0;
    int gap_cnt   = 0;
    int burst_cnt = 0;
    int hold_cnt  = 0;
    int res_seen  = 0;
    int err_cnt   = 0;

    // ---------------------------------------------------------------------------------
    // Predictor. Each square is moved by coordinates rather than by mask networks:
    // transpose swaps row and column, the byte swap flips the row, the mirror flips
    // the column, applied in that order.
    // ---------------------------------------------------------------------------------
    function automatic t_plane sq_map(input t_plane b, input t_code code);
        t_plane r;
        int     nr;
        int     nc;
        int     tmp;
        r = '0;
        for (int row = 0; row < 8; row++) begin
            for (int col = 0; col < 8; col++) begin
                nr = row;
                nc = col;
                if (code[CodeBitT]) begin
                    tmp = nr;
                    nr  = nc;
                    nc  = tmp;
                end
                if (code[CodeBitV]) nr = 7 - nr;
                if (code[CodeBitH]) nc = 7 - nc;
                r[8*nr+nc] = b[8*row+col];
            end
        end
        return r;
    endfunction

    function automatic t_key map_key(input t_key k, input t_code code);
        t_key r;
        r.top   = sq_map(k.top, code);
        r.mid   = sq_map(k.mid, code);
        r.low   = sq_map(k.low, code);
        r.owner = sq_map(k.owner, code);
        return r;
    endfunction

    // The packed key has the top layer in its most significant bits, so a plain
    // unsigned compare of the whole key is the lexicographic order. A strict compare
    // keeps the lowest code on ties.
    function automatic t_cand canon_predict(input t_key k);
        t_cand best;
        t_cand cand;
        best.key  = k;
        best.code = '0;
        for (int i = 1; i < NumImages; i++) begin
            cand.key  = map_key(k, t_code'(i));
            cand.code = t_code'(i);
            if (cand.key < best.key) best = cand;
        end
        return best;
    endfunction

    // ---------------------------------------------------------------------------------
    // Stimulus helpers.
    // ---------------------------------------------------------------------------------
    function automatic t_plane rand64();
        return {$urandom, $urandom};
    endfunction

    // Union of all eight images, which is invariant under every symmetry.
    function automatic t_plane sym_close(input t_plane b);
        t_plane r;
        r = '0;
        for (int i = 0; i < NumImages; i++) r |= sq_map(b, t_code'(i));
        return r;
    endfunction

    task automatic push_pos(input t_plane top, input t_plane mid, input t_plane low,
                            input t_plane owner, input bit drain);
        t_pos_item it;
        it.key.top      = top;
        it.key.mid      = mid;
        it.key.low      = low;
        it.key.owner    = owner;
        it.drain_first  = drain;
        pending_q.push_back(it);
    endtask

    task automatic report_field(input string name, input t_plane exp_v, input t_plane got_v);
        err_cnt++;
        if (err_cnt <= MaxReports) begin
            $display("%0t ns: result %0d field %s mismatch: expected %h, got %h",
                     $time, res_seen, name, exp_v, got_v);
        end
    endtask

    // ---------------------------------------------------------------------------------
    // Clock.
    // ---------------------------------------------------------------------------------
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------
    // Input driver. A new position is presented only when the inputs are empty or the
    // previous one was transferred at the last rising edge; a stalled position stays.
    // Random gaps follow some transfers until the quiet tail.
    // ---------------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic      nv;
        t_pos_item it;
        if (rst_done) begin
            nv = i_valid;
            if (!i_valid || in_taken) begin
                nv = 1'b0;
                if (i_valid && !quiet_r && $urandom_range(0, 5) == 0) begin
                    gap_cnt = $urandom_range(1, 8);
                end
                if (gap_cnt > 0) begin
                    gap_cnt--;
                end else if (pending_q.size() > 0 &&
                             (!pending_q[0].drain_first || canon_q.size() == 0)) begin
                    it            = pending_q.pop_front();
                    nv            = 1'b1;
                    i_layer_top   <= it.key.top;
                    i_layer_mid   <= it.key.mid;
                    i_layer_low   <= it.key.low;
                    i_owner_plane <= it.key.owner;
                    if (pending_q.size() < QuietTail) quiet_r <= 1'b1;
                end
            end
            i_valid <= nv;
        end
    end

    // ---------------------------------------------------------------------------------
    // Output stall generator. Short random bursts, plus one long hold-off counted here
    // while the driver keeps offering, so the pipeline fills and stalls its input.
    // ---------------------------------------------------------------------------------
    always @(negedge i_clk) begin
        logic ns;
        if (rst_done) begin
            if (!long_done && res_seen >= LongHoldAt) begin
                hold_cnt  = LongHoldCycles;
                long_done = 1'b1;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                ns = 1'b1;
            end else if (burst_cnt > 0) begin
                burst_cnt--;
                ns = 1'b1;
            end else if (!quiet_r && $urandom_range(0, 7) == 0) begin
                burst_cnt = $urandom_range(1, 8) - 1;
                ns = 1'b1;
            end else begin
                ns = 1'b0;
            end
            i_stall <= ns;
        end
    end

    // ---------------------------------------------------------------------------------
    // Monitor. Every input transfer pushes its predicted canonical image; every output
    // transfer is checked field by field against the oldest prediction.
    // ---------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_cand exp_r;
        t_key  in_key;
        if (rst_done) begin
            in_taken <= i_valid && !o_stall;
            if (i_valid && !o_stall) begin
                in_key.top   = i_layer_top;
                in_key.mid   = i_layer_mid;
                in_key.low   = i_layer_low;
                in_key.owner = i_owner_plane;
                canon_q.push_back(canon_predict(in_key));
            end
            if (o_valid && !i_stall) begin
                if (canon_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= MaxReports) begin
                        $display("%0t ns: result transfer with no position outstanding",
                                 $time);
                    end
                end else begin
                    exp_r = canon_q.pop_front();
                    if (o_canon_top !== exp_r.key.top)
                        report_field("canon_top", exp_r.key.top, o_canon_top);
                    if (o_canon_mid !== exp_r.key.mid)
                        report_field("canon_mid", exp_r.key.mid, o_canon_mid);
                    if (o_canon_low !== exp_r.key.low)
                        report_field("canon_low", exp_r.key.low, o_canon_low);
                    if (o_canon_owner !== exp_r.key.owner)
                        report_field("canon_owner", exp_r.key.owner, o_canon_owner);
                    if (o_sym_code !== exp_r.code)
                        report_field("sym_code", 64'(exp_r.code), 64'(o_sym_code));
                end
                res_seen++;
            end
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus, reset and end of run.
    // ---------------------------------------------------------------------------------
    initial begin
        t_key   base;
        t_key   img;
        t_plane r;
        int     cat;

        // Directed positions: empty and full boards, single corner squares, one
        // image of a random board under every code, keys decided by lower planes,
        // symmetric boards that tie, and physically impossible stacks.
        push_pos('0, '0, '0, '0, 1'b0);
        push_pos('1, '1, '1, '1, 1'b0);
        push_pos('1, '0, '0, '0, 1'b0);
        push_pos('0, '0, '0, rand64(), 1'b0);
        push_pos(64'h1, '0, '0, '0, 1'b0);
        push_pos(64'h1 << 63, 64'h1 << 63, 64'h1 << 63, 64'h1 << 63, 1'b0);
        push_pos(64'h1 << 62, '0, '0, '0, 1'b0);
        base.top   = rand64();
        base.mid   = rand64();
        base.low   = rand64();
        base.owner = rand64();
        for (int i = 0; i < NumImages; i++) begin
            img = map_key(base, t_code'(i));
            push_pos(img.top, img.mid, img.low, img.owner, 1'b0);
        end
        push_pos('0, '0, '0, rand64(), 1'b0);
        push_pos('0, '0, rand64(), rand64(), 1'b0);
        push_pos('0, rand64(), rand64(), rand64(), 1'b0);
        push_pos(64'h0000_0018_1800_0000, sym_close(rand64()), '0, rand64(), 1'b0);
        push_pos(64'h8040_2010_0804_0201, rand64(), rand64(), rand64(), 1'b0);
        r = sym_close(rand64());
        push_pos(r, r, r, r, 1'b0);
        push_pos(MaskBitLo, MaskBitHi, '0, '0, 1'b0);
        push_pos('1, '0, '0, MaskBitHi, 1'b0);

        // Random positions. Full-random boards rarely tie, so a good share are
        // symmetric or sparse, or leave the upper planes empty so lower ones decide.
        for (int n = 0; n < RandomCount; n++) begin
            cat = $urandom_range(0, 9);
            unique case (cat)
                0, 1, 2, 3: begin
                    base.top   = rand64();
                    base.mid   = rand64();
                    base.low   = rand64();
                    base.owner = rand64();
                end
                4, 5: begin
                    base.top   = rand64() & rand64() & rand64();
                    base.mid   = rand64() & rand64() & rand64();
                    base.low   = rand64() & rand64() & rand64();
                    base.owner = rand64() & rand64();
                end
                6: begin
                    base.top   = sym_close(rand64() & rand64() & rand64());
                    base.mid   = ($urandom_range(0, 1) != 0) ? sym_close(rand64() & rand64())
                                                             : rand64();
                    base.low   = rand64();
                    base.owner = rand64();
                end
                7: begin
                    base.top   = sym_close(rand64() & rand64() & rand64());
                    base.mid   = sym_close(rand64() & rand64() & rand64());
                    base.low   = sym_close(rand64() & rand64());
                    base.owner = ($urandom_range(0, 1) != 0) ? sym_close(rand64() & rand64())
                                                             : rand64() & rand64() & rand64();
                end
                8: begin
                    base.top   = '0;
                    base.mid   = ($urandom_range(0, 1) != 0) ? '0 : rand64() & rand64();
                    base.low   = ($urandom_range(0, 2) != 0) ? rand64() : '0;
                    base.owner = rand64();
                end
                default: begin
                    // A legal stack: upper layers only where the layer below is filled,
                    // colours only on occupied squares.
                    base.low   = rand64();
                    base.mid   = base.low & rand64();
                    base.top   = base.mid & rand64() & rand64();
                    base.owner = base.low & rand64();
                end
            endcase
            // One pause of the sender until the pipeline has drained completely.
            push_pos(base.top, base.mid, base.low, base.owner, n == RandomCount / 2);
        end

        // Synchronous reset, released at a falling edge.
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  = 1'b1;
        rst_done = 1'b1;

        while (pending_q.size() != 0 || i_valid || canon_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (TailCycles) @(negedge i_clk);

        if (err_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
